FILE: rtl/scn_pkg.sv
// ----------------------------------------------------------------------------
// scn_pkg
// Shared types and constants for the sensor calibrate / normalize block.
// ----------------------------------------------------------------------------
package scn_pkg;

    // beat field widths
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 3;
    localparam int SMP_W  = 12;
    localparam int NORM_W = 17;
    localparam int FRAC_W = 16;
    localparam int STEP_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NORMALIZE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACC_WHITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ACC_BLACK = 2'd3;

    // 1.0 in unsigned Q1.16
    localparam logic [NORM_W-1:0] Q_ONE = 17'h10000;

    // quotient bits for the average and for the normalized fraction
    localparam logic [STEP_W-1:0] AVG_STEPS  = 5'd12;
    localparam logic [STEP_W-1:0] NORM_STEPS = 5'd16;

    // divider request from the sequencer
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } scn_div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } scn_div_sts_t;

endpackage

FILE: rtl/scn_div.sv
// ----------------------------------------------------------------------------
// scn_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scn_div #(
    parameter int DV_W = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  scn_pkg::scn_div_req_t      req,
    input  logic [DV_W-1:0]            rem_init,   // partial remainder, below divisor
    input  logic [DV_W-1:0]            divisor,
    input  logic [scn_pkg::FRAC_W-1:0] dividend,   // low bits, msb shifted in first
    output scn_pkg::scn_div_sts_t      sts,
    output logic [scn_pkg::FRAC_W-1:0] quotient
);

    logic [DV_W-1:0]            rem_reg, rem_next;
    logic [DV_W-1:0]            den_reg;
    logic [scn_pkg::FRAC_W-1:0] shf_reg;
    logic [scn_pkg::FRAC_W-1:0] quo_reg;
    logic [scn_pkg::STEP_W-1:0] cnt_reg;
    logic                       done_reg;
    logic [DV_W:0]              part;
    logic [DV_W:0]              diff;
    logic                       ge;

    // one trial subtraction
    always_comb begin
        part     = {rem_reg, shf_reg[scn_pkg::FRAC_W-1]};
        diff     = part - {1'b0, den_reg};
        ge       = (part >= {1'b0, den_reg});
        rem_next = ge ? diff[DV_W-1:0] : part[DV_W-1:0];
    end

    // step counter and done flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            cnt_reg  <= req.steps;
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - scn_pkg::STEP_W'(1);
            done_reg <= (cnt_reg == scn_pkg::STEP_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= rem_init;
            den_reg <= divisor;
            shf_reg <= dividend;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            shf_reg <= {shf_reg[scn_pkg::FRAC_W-2:0], 1'b0};
            quo_reg <= {quo_reg[scn_pkg::FRAC_W-2:0], ge};
        end
    end

    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/sensor_calibrate_normalize_unit.sv
// ----------------------------------------------------------------------------
// sensor_calibrate_normalize_unit
// Per-sensor white/black calibration by running average, and normalization
// of samples to unsigned Q1.16 through one shared serial divider.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | contents
//  s_       | in  | s_tvalid s_tready s_tdata s_tuser s_tlast | sample beat
//  m_       | out | m_tvalid m_tready m_tdata m_tuser m_tlast | normalized beat
//  cfg_     | in  | cfg_wr_en cfg_wr_data             | calibrated flag
//
// s_tready is low while a beat is in work, from the cycle after the accept cycle:
// normalize through the divider: prep, quotient bits, done, out; normalize
// with an early 0 or 1.0 answer: prep, out; accumulate: prep, load, divider
// steps, done; clear, uncalibrated or saturated beats: prep; bad index: none.
// A finished result waits in the output register and holds the sequencer only
// if the next result is due before m_tready. Reset clears levels, sums, counts.
module sensor_calibrate_normalize_unit #(
    parameter int SENSOR_COUNT = 8,
    parameter int MAX_SAMPLES  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] sensor_index, [14:3] sample, [15] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        s_tlast,   // last_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] normalized, [19:17] out_sensor_index, rest zero
    output logic        m_tuser,   // [0] zero_span
    output logic        m_tlast    // out_last_of_frame
);

    localparam int AW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = scn_pkg::SMP_W + CNT_W;
    localparam int DV_W  = (CNT_W > scn_pkg::SMP_W) ? CNT_W : scn_pkg::SMP_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_AVG  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                   state_reg;
    logic                         calibrated_reg;
    logic [scn_pkg::CMD_W-1:0]    cmd_reg;
    logic [scn_pkg::IDX_W-1:0]    idx_reg;
    logic [scn_pkg::SMP_W-1:0]    smp_reg;
    logic                         last_reg;
    logic [scn_pkg::NORM_W-1:0]   res_reg;
    logic                         zspan_reg;

    logic [scn_pkg::SMP_W-1:0]    white_arr [SENSOR_COUNT];
    logic [scn_pkg::SMP_W-1:0]    black_arr [SENSOR_COUNT];
    logic [SUM_W-1:0]             sum_arr   [SENSOR_COUNT];
    logic [CNT_W-1:0]             cnt_arr   [SENSOR_COUNT];

    logic                         m_valid_reg;
    logic [scn_pkg::NORM_W-1:0]   m_norm_reg;
    logic [scn_pkg::IDX_W-1:0]    m_idx_reg;
    logic                         m_last_reg;
    logic                         m_zspan_reg;

    logic [AW-1:0]                addr;
    logic                         s_fire;
    logic                         out_free;
    logic [scn_pkg::SMP_W:0]      d_val, s_val;
    logic [scn_pkg::SMP_W-1:0]    d_abs, s_abs;
    logic                         acc_full;

    scn_pkg::scn_div_req_t        div_req;
    scn_pkg::scn_div_sts_t        div_sts;
    logic [DV_W-1:0]              div_rem;
    logic [DV_W-1:0]              div_den;
    logic [scn_pkg::FRAC_W-1:0]   div_dvd;
    logic [scn_pkg::FRAC_W-1:0]   div_quo;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign addr     = AW'(idx_reg);

    // signed differences to the white level and their magnitudes
    always_comb begin
        d_val    = {1'b0, smp_reg} - {1'b0, white_arr[addr]};
        s_val    = {1'b0, black_arr[addr]} - {1'b0, white_arr[addr]};
        d_abs    = d_val[scn_pkg::SMP_W] ? scn_pkg::SMP_W'(-d_val)
                                         : d_val[scn_pkg::SMP_W-1:0];
        s_abs    = s_val[scn_pkg::SMP_W] ? scn_pkg::SMP_W'(-s_val)
                                         : s_val[scn_pkg::SMP_W-1:0];
        acc_full = (cnt_arr[addr] >= CNT_W'(MAX_SAMPLES));
    end

    // divider operand selection
    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = scn_pkg::NORM_STEPS;
        div_rem       = DV_W'(d_abs);
        div_den       = DV_W'(s_abs);
        div_dvd       = '0;
        if (state_reg == ST_AVG) begin
            div_req.start = 1'b1;
            div_req.steps = scn_pkg::AVG_STEPS;
            div_rem       = DV_W'(sum_arr[addr][SUM_W-1:scn_pkg::SMP_W]);
            div_den       = DV_W'(cnt_arr[addr]);
            div_dvd       = {sum_arr[addr][scn_pkg::SMP_W-1:0],
                             {(scn_pkg::FRAC_W - scn_pkg::SMP_W){1'b0}}};
        end else if (state_reg == ST_PREP && cmd_reg == scn_pkg::CMD_NORMALIZE
                     && calibrated_reg && s_val != '0 && d_val != '0
                     && d_val[scn_pkg::SMP_W] == s_val[scn_pkg::SMP_W]
                     && d_abs < s_abs) begin
            div_req.start = 1'b1;
        end
    end

    scn_div #(
        .DV_W (DV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rem_init (div_rem),
        .divisor  (div_den),
        .dividend (div_dvd),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibrated_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            calibrated_reg <= cfg_wr_data;
        end
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= s_tuser;
            idx_reg  <= s_tdata[scn_pkg::IDX_W-1:0];
            smp_reg  <= s_tdata[scn_pkg::IDX_W +: scn_pkg::SMP_W];
            last_reg <= s_tlast;
        end
    end

    // sequencer and per-sensor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                white_arr[i] <= '0;
                black_arr[i] <= '0;
                sum_arr[i]   <= '0;
                cnt_arr[i]   <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (32'(s_tdata[scn_pkg::IDX_W-1:0]) < SENSOR_COUNT) begin
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    unique case (cmd_reg)
                        scn_pkg::CMD_NORMALIZE: begin
                            if (!calibrated_reg) begin
                                state_reg <= ST_IDLE;
                            end else if (div_req.start) begin
                                state_reg <= ST_DIV;
                            end else begin
                                state_reg <= ST_OUT;
                            end
                        end
                        scn_pkg::CMD_CLEAR: begin
                            sum_arr[addr] <= '0;
                            cnt_arr[addr] <= '0;
                            state_reg     <= ST_IDLE;
                        end
                        default: begin
                            if (acc_full) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                sum_arr[addr] <= sum_arr[addr] + SUM_W'(smp_reg);
                                cnt_arr[addr] <= cnt_arr[addr] + CNT_W'(1);
                                state_reg     <= ST_AVG;
                            end
                        end
                    endcase
                end
                ST_AVG: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_sts.done) begin
                        if (cmd_reg == scn_pkg::CMD_NORMALIZE) begin
                            state_reg <= ST_OUT;
                        end else begin
                            if (cmd_reg == scn_pkg::CMD_ACC_WHITE) begin
                                white_arr[addr] <= div_quo[scn_pkg::SMP_W-1:0];
                            end else begin
                                black_arr[addr] <= div_quo[scn_pkg::SMP_W-1:0];
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result value: early answers in prep, quotient after the divider
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PREP) begin
            zspan_reg <= (s_val == '0);
            if (s_val == '0 || d_val == '0
                || d_val[scn_pkg::SMP_W] != s_val[scn_pkg::SMP_W]) begin
                res_reg <= '0;
            end else begin
                res_reg <= scn_pkg::Q_ONE;
            end
        end else if (state_reg == ST_DIV && div_sts.done) begin
            res_reg <= {1'b0, div_quo};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_norm_reg  <= res_reg;
            m_idx_reg   <= idx_reg;
            m_last_reg  <= last_reg;
            m_zspan_reg <= zspan_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_idx_reg, m_norm_reg};
    assign m_tuser  = m_zspan_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: tb/tb_sensor_calibrate_normalize_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_calibrate_normalize_unit
// Self-checking bench for the sensor calibrate / normalize block. Sample beats
// go in with random gaps and the result channel sees random back-pressure. A
// per-sensor tracker keeps the white/black levels and the accumulators, and
// it works out each normalized reading. Received beats are compared in order.
// The stimulus has a directed opening, a run that drives one sensor's count
// past its limit, and then random calibration, scan-frame, noise and flag phases.
// ----------------------------------------------------------------------------
module tb_sensor_calibrate_normalize_unit;

    localparam int NUM_SENSORS   = 8;
    localparam int SAT_LIMIT     = 1024;
    localparam int RANDOM_BEATS  = 170;
    localparam int SETTLE_CYCLES = 32;

    // one expected result beat
    typedef struct packed {
        logic [scn_pkg::NORM_W-1:0] level;
        logic [scn_pkg::IDX_W-1:0]  sensor;
        logic                       last;
        logic                       zero_span;
    } reading_t;

    // per-sensor levels and accumulators, plus the queue of due readings
    class scn_level_tracker;
        bit                        calibrated = 0;
        logic [scn_pkg::SMP_W-1:0] white_ref [NUM_SENSORS] = '{default: '0};
        logic [scn_pkg::SMP_W-1:0] black_ref [NUM_SENSORS] = '{default: '0};
        logic [22:0]               acc_sum   [NUM_SENSORS] = '{default: '0};
        logic [10:0]               acc_count [NUM_SENSORS] = '{default: '0};
        reading_t                  due_readings[$];
        int                        mismatches = 0;

        // (smp-white)/(black-white) in Q1.16, truncated, clamped to 0..1.0
        function logic [scn_pkg::NORM_W-1:0] q16_ratio(int smp, int wht, int blk);
            int              d;
            int              s;
            longint unsigned q;
            d = smp - wht;
            s = blk - wht;
            if (s == 0 || d == 0 || ((d < 0) != (s < 0)))
                return '0;
            if (d < 0) begin
                d = -d;
                s = -s;
            end
            q = (longint'(d) * 65536) / s;
            if (q > scn_pkg::Q_ONE)
                return scn_pkg::Q_ONE;
            return q[scn_pkg::NORM_W-1:0];
        endfunction

        // update state for one accepted sample beat
        function void note_sample(logic [scn_pkg::CMD_W-1:0] cmd,
                                  logic [scn_pkg::IDX_W-1:0] idx,
                                  logic [scn_pkg::SMP_W-1:0] smp, logic last);
            reading_t    r;
            logic [22:0] avg;
            case (cmd)
                scn_pkg::CMD_NORMALIZE: begin
                    if (calibrated) begin
                        r.level     = q16_ratio(int'(smp), int'(white_ref[idx]),
                                                int'(black_ref[idx]));
                        r.sensor    = idx;
                        r.last      = last;
                        r.zero_span = (white_ref[idx] == black_ref[idx]);
                        due_readings.push_back(r);
                    end
                end
                scn_pkg::CMD_CLEAR: begin
                    acc_sum[idx]   = '0;
                    acc_count[idx] = '0;
                end
                default: begin
                    // shared accumulator; samples past the limit are dropped
                    if (int'(acc_count[idx]) < SAT_LIMIT) begin
                        acc_sum[idx]   = acc_sum[idx] + 23'(smp);
                        acc_count[idx] = acc_count[idx] + 11'd1;
                        avg = acc_sum[idx] / 23'(acc_count[idx]);
                        if (cmd == scn_pkg::CMD_ACC_WHITE)
                            white_ref[idx] = avg[scn_pkg::SMP_W-1:0];
                        else
                            black_ref[idx] = avg[scn_pkg::SMP_W-1:0];
                    end
                end
            endcase
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        // compare one received beat with the oldest due reading
        task check_beat(logic [23:0] tdata, logic tuser, logic tlast);
            reading_t want;
            if (due_readings.size() == 0) begin
                flag_mismatch($sformatf("beat with nothing due, tdata=%h", tdata));
                return;
            end
            want = due_readings.pop_front();
            if (tdata[16:0] != want.level)
                flag_mismatch($sformatf("normalized %0d, want %0d (sensor %0d)",
                                        tdata[16:0], want.level, want.sensor));
            if (tdata[19:17] != want.sensor)
                flag_mismatch($sformatf("sensor index %0d, want %0d",
                                        tdata[19:17], want.sensor));
            if (tdata[23:20] != '0)
                flag_mismatch($sformatf("tdata pad bits %h not zero", tdata[23:20]));
            if (tlast != want.last)
                flag_mismatch($sformatf("tlast %0b, want %0b (sensor %0d)",
                                        tlast, want.last, want.sensor));
            if (tuser != want.zero_span)
                flag_mismatch($sformatf("zero_span %0b, want %0b (sensor %0d)",
                                        tuser, want.zero_span, want.sensor));
        endtask
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [2:0] sensor_index, [14:3] sample, [15] zero
    logic [1:0]  s_tuser     = '0;   // [1:0] command
    logic        s_tlast     = 1'b0; // last_of_frame
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;            // [16:0] normalized, [19:17] out_sensor_index
    logic        m_tuser;            // [0] zero_span
    logic        m_tlast;            // out_last_of_frame

    scn_level_tracker tracker = new;
    int               accepted_beats = 0;
    bit               calm = 1'b0;

    always #6 aclk = ~aclk;

    sensor_calibrate_normalize_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_wait();
        int r;
        r = $urandom_range(0, 15);
        if (calm || r < 8)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    // sample near a center value, kept inside the converter range
    function automatic logic [scn_pkg::SMP_W-1:0] jitter(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[scn_pkg::SMP_W-1:0];
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_beat(logic [scn_pkg::CMD_W-1:0] cmd,
                             logic [scn_pkg::IDX_W-1:0] idx,
                             logic [scn_pkg::SMP_W-1:0] smp, logic last);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {1'b0, smp, idx};
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        tracker.note_sample(cmd, idx, smp, last);
        accepted_beats++;
        @(negedge aclk);
    endtask

    // wait until every due reading is in and the block has gone quiet
    task automatic wait_drained();
        while (tracker.due_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_calibrated(bit value);
        s_tvalid = 1'b0;
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        tracker.calibrated = value;
    endtask

    // clear / white run / clear / black run, sometimes without the clears
    task automatic calibrate_sensor(logic [scn_pkg::IDX_W-1:0] idx);
        int base_w;
        int base_b;
        int spread;
        base_w = $urandom_range(0, 4095);
        base_b = ($urandom_range(0, 15) == 0) ? base_w : $urandom_range(0, 4095);
        spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
        if ($urandom_range(0, 7) != 0)
            send_beat(scn_pkg::CMD_CLEAR, idx, scn_pkg::SMP_W'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 8))
            send_beat(scn_pkg::CMD_ACC_WHITE, idx, jitter(base_w, spread),
                      1'($urandom));
        if ($urandom_range(0, 7) != 0)
            send_beat(scn_pkg::CMD_CLEAR, idx, scn_pkg::SMP_W'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 8))
            send_beat(scn_pkg::CMD_ACC_BLACK, idx, jitter(base_b, spread),
                      1'($urandom));
    endtask

    // full scan frames of normalize beats, tlast on the final sensor, now and then flipped
    task automatic scan_frames(int frames);
        int                        lo;
        int                        hi;
        logic [scn_pkg::SMP_W-1:0] smp;
        logic                      last;
        for (int f = 0; f < frames; f++) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                lo = int'(tracker.white_ref[k]);
                hi = int'(tracker.black_ref[k]);
                if (lo > hi) begin
                    lo = int'(tracker.black_ref[k]);
                    hi = int'(tracker.white_ref[k]);
                end
                if ($urandom_range(0, 2) == 0)
                    smp = scn_pkg::SMP_W'($urandom);
                else
                    smp = jitter(int'($urandom_range(lo, hi)), 40);
                last = (k == NUM_SENSORS - 1) ^ ($urandom_range(0, 15) == 0);
                send_beat(scn_pkg::CMD_NORMALIZE, scn_pkg::IDX_W'(k), smp, last);
            end
        end
    endtask

    // result side back-pressure
    initial begin : ready_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (calm)
                hold_left = 0;
            else if (hold_left == 0 && $urandom_range(0, 3) == 0)
                hold_left = pick_wait();
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result beats checked at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_beat(m_tdata, m_tuser, m_tlast);
    end

    initial begin : stimulus
        int                        start_beats;
        int                        drain_cycles;
        logic [scn_pkg::IDX_W-1:0] sat_idx;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // normalize while uncalibrated gives nothing
        write_calibrated(1'b0);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd0, 12'd2048, 1'b0);
        // reset levels are equal: zero span
        write_calibrated(1'b1);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd7, 12'd4095, 1'b1);

        // sensor 0: white 100, black 4000
        send_beat(scn_pkg::CMD_CLEAR,     3'd0, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_ACC_WHITE, 3'd0, 12'd100,  1'b0);
        send_beat(scn_pkg::CMD_CLEAR,     3'd0, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_ACC_BLACK, 3'd0, 12'd4000, 1'b0);
        // below white, at white, at black, beyond black, in between
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd0, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd0, 12'd100,  1'b0);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd0, 12'd4000, 1'b1);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd0, 12'd4095, 1'b0);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd0, 12'd2050, 1'b1);

        // sensor 1: inverted polarity, white 4095, black 0
        send_beat(scn_pkg::CMD_CLEAR,     3'd1, 12'd0,    1'b1);
        send_beat(scn_pkg::CMD_ACC_WHITE, 3'd1, 12'd4095, 1'b1);
        send_beat(scn_pkg::CMD_CLEAR,     3'd1, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_ACC_BLACK, 3'd1, 12'd0,    1'b1);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd1, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd1, 12'd4095, 1'b1);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd1, 12'd1234, 1'b0);

        // sensor 2: truncated average, then equal nonzero levels
        send_beat(scn_pkg::CMD_CLEAR,     3'd2, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_ACC_WHITE, 3'd2, 12'd3000, 1'b0);
        send_beat(scn_pkg::CMD_ACC_WHITE, 3'd2, 12'd3001, 1'b0);
        send_beat(scn_pkg::CMD_CLEAR,     3'd2, 12'd0,    1'b0);
        send_beat(scn_pkg::CMD_ACC_BLACK, 3'd2, 12'd3000, 1'b0);
        send_beat(scn_pkg::CMD_NORMALIZE, 3'd2, 12'd3500, 1'b1);

        // drive one sensor's count to the limit and past it
        sat_idx = scn_pkg::IDX_W'($urandom_range(0, NUM_SENSORS - 1));
        send_beat(scn_pkg::CMD_CLEAR, sat_idx, scn_pkg::SMP_W'($urandom), 1'($urandom));
        repeat (SAT_LIMIT - 1)
            send_beat($urandom_range(0, 1) ? scn_pkg::CMD_ACC_WHITE
                                           : scn_pkg::CMD_ACC_BLACK,
                      sat_idx, scn_pkg::SMP_W'($urandom), 1'($urandom));
        send_beat(scn_pkg::CMD_ACC_BLACK, sat_idx, 12'd0, 1'b0);
        repeat (4) send_beat(scn_pkg::CMD_ACC_WHITE, sat_idx, 12'd4095, 1'($urandom));
        repeat (4) send_beat(scn_pkg::CMD_ACC_BLACK, sat_idx, 12'd4095, 1'($urandom));
        scan_frames(2);

        // random phases
        start_beats = accepted_beats;
        while (accepted_beats - start_beats < RANDOM_BEATS) begin
            calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (int k = 0; k < NUM_SENSORS; k++)
                        if ($urandom_range(0, 1) == 1)
                            calibrate_sensor(scn_pkg::IDX_W'(k));
                end
                3, 4, 5, 6: scan_frames($urandom_range(1, 4));
                7: begin
                    repeat ($urandom_range(4, 20))
                        send_beat(scn_pkg::CMD_W'($urandom), scn_pkg::IDX_W'($urandom),
                                  scn_pkg::SMP_W'($urandom), 1'($urandom));
                end
                default: write_calibrated($urandom_range(0, 3) != 0);
            endcase
        end
        calm = 1'b0;

        // drain and settle
        s_tvalid = 1'b0;
        drain_cycles = 0;
        while (tracker.due_readings.size() != 0 && drain_cycles < 5000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.due_readings.size() != 0)
            tracker.flag_mismatch($sformatf("%0d readings never arrived",
                                            tracker.due_readings.size()));
        if (tracker.mismatches == 0) begin
            $display("sensor_calibrate_normalize_unit: match");
        end else begin
            $display("sensor_calibrate_normalize_unit: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #20_000_000;
        $display("sensor_calibrate_normalize_unit: mismatch");
        $finish;
    end

endmodule
